FILE: src/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared widths, angle constants, arctangent table and rounded Q30 multiply
// for the great-circle distance pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package gcd_pkg;

    localparam int FRACTION_BITS = 28;
    localparam int WORK_BITS     = 30;
    localparam int CORDIC_STEPS  = 30;
    localparam int IN_SHIFT      = WORK_BITS - FRACTION_BITS;
    localparam int OUT_SHIFT     = WORK_BITS - FRACTION_BITS;

    localparam int LNG_W = 31;
    localparam int LAT_W = 30;
    localparam int OUT_W = 30;
    localparam int THR_W = 11;
    localparam int AW    = 35;
    localparam int VW    = 36;

    localparam int ROT_LAT   = 3 + CORDIC_STEPS + 1;
    localparam int VEC_LAT   = 1 + CORDIC_STEPS + 1;
    localparam int MUL_LAT   = 3;
    localparam int FIN_LAT   = 2;
    localparam int TOTAL_LAT = 1 + ROT_LAT + MUL_LAT + 2 * VEC_LAT + FIN_LAT;

    localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
    localparam logic [63:0] PI_U     = (PI_Q60 + (64'd1 << 29)) >> 30;
    localparam logic [63:0] TWO_PI_U = (PI_Q60 + (64'd1 << 28)) >> 29;
    localparam logic [63:0] HALF_U   = (PI_Q60 + (64'd1 << 30)) >> 31;

    localparam logic signed [AW-1:0] PI_A      = AW'(PI_U);
    localparam logic signed [AW-1:0] TWO_PI_A  = AW'(TWO_PI_U);
    localparam logic signed [AW-1:0] HALF_PI_A = AW'(HALF_U);
    localparam logic signed [VW-1:0] PI_V      = VW'(PI_U);
    localparam logic signed [VW-1:0] GAIN_K    = VW'(64'h26DD3B6A);

    localparam logic [OUT_W-1:0] OUT_MAX   = {OUT_W{1'b1}};
    localparam logic [OUT_W-1:0] OUT_PI    = OUT_W'((PI_U + (64'd1 << (OUT_SHIFT - 1)))
                                                    >> OUT_SHIFT);
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

    localparam logic signed [2*VW-1:0] MUL_HALF = (2*VW)'(64'd1 << (WORK_BITS - 1));
    localparam logic [VW-1:0]          OUT_RND  = VW'(64'd1 << (OUT_SHIFT - 1));

    function automatic logic [63:0] atan_entry(input int i);
        logic [63:0] sum;
        logic [63:0] term;
        int          k;
        int          p;
        sum = 64'd0;
        if (i == 0) begin
            return ((PI_Q60 >> 2) + (64'd1 << 29)) >> 30;
        end
        for (k = 0; k < 61; k++) begin
            p = i * (2 * k + 1);
            if (p <= 60) begin
                term = (64'd1 << (60 - p)) / 64'(2 * k + 1);
                if (k[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        return (sum + (64'd1 << 29)) >> 30;
    endfunction

    function automatic logic signed [VW-1:0] mulq(input logic signed [VW-1:0] a,
                                                  input logic signed [VW-1:0] b);
        logic signed [2*VW-1:0] p;
        p = a * b + MUL_HALF;
        return VW'(p >>> WORK_BITS);
    endfunction

endpackage

`default_nettype wire

FILE: src/gcd_rot.sv
// ----------------------------------------------------------------------------
// gcd_rot
// Pipelined sine/cosine: range reduction in three stages, one CORDIC
// rotation step per stage, then quadrant sign fix-up.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_rot (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [gcd_pkg::AW-1:0]  i_ang,
    output logic signed [gcd_pkg::VW-1:0]  o_sin,
    output logic signed [gcd_pkg::VW-1:0]  o_cos
);
    import gcd_pkg::*;

    logic signed [AW-1:0] r_a1;
    logic signed [AW-1:0] r_a2;
    logic signed [VW-1:0] r_x   [0:CORDIC_STEPS];
    logic signed [VW-1:0] r_y   [0:CORDIC_STEPS];
    logic signed [AW-1:0] r_z   [0:CORDIC_STEPS-1];
    logic                 r_neg [0:CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_ang >= TWO_PI_A) begin
                r_a1 <= i_ang - TWO_PI_A;
            end else if (i_ang <= -TWO_PI_A) begin
                r_a1 <= i_ang + TWO_PI_A;
            end else begin
                r_a1 <= i_ang;
            end

            if (r_a1 > PI_A) begin
                r_a2 <= r_a1 - TWO_PI_A;
            end else if (r_a1 < -PI_A) begin
                r_a2 <= r_a1 + TWO_PI_A;
            end else begin
                r_a2 <= r_a1;
            end

            r_x[0] <= GAIN_K;
            r_y[0] <= '0;
            if (r_a2 > HALF_PI_A) begin
                r_z[0]   <= r_a2 - PI_A;
                r_neg[0] <= 1'b1;
            end else if (r_a2 < -HALF_PI_A) begin
                r_z[0]   <= r_a2 + PI_A;
                r_neg[0] <= 1'b1;
            end else begin
                r_z[0]   <= r_a2;
                r_neg[0] <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        localparam logic signed [AW-1:0] T = AW'(atan_entry(i));
        logic signed [VW-1:0] dx;
        logic signed [VW-1:0] dy;

        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - dx;
                    r_y[i+1] <= r_y[i] + dy;
                end else begin
                    r_x[i+1] <= r_x[i] + dx;
                    r_y[i+1] <= r_y[i] - dy;
                end
                r_neg[i+1] <= r_neg[i];
            end
        end

        if (i < CORDIC_STEPS - 1) begin : g_ang
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_z[i+1] <= (r_z[i] >= 0) ? r_z[i] - T : r_z[i] + T;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sin <= r_neg[CORDIC_STEPS] ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS];
            o_cos <= r_neg[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
        end
    end

endmodule

`default_nettype wire

FILE: src/gcd_vec.sv
// ----------------------------------------------------------------------------
// gcd_vec
// Pipelined CORDIC vectoring: left half-plane fold, one step per stage,
// gain-corrected magnitude and angle out.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_vec (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [gcd_pkg::VW-1:0]  i_x,
    input  logic signed [gcd_pkg::VW-1:0]  i_y,
    output logic signed [gcd_pkg::VW-1:0]  o_mag,
    output logic signed [gcd_pkg::VW-1:0]  o_ang
);
    import gcd_pkg::*;

    logic signed [VW-1:0] r_x [0:CORDIC_STEPS];
    logic signed [VW-1:0] r_y [0:CORDIC_STEPS];
    logic signed [VW-1:0] r_z [0:CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_x < 0) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_z[0] <= (i_y >= 0) ? PI_V : -PI_V;
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        localparam logic signed [VW-1:0] T = VW'(atan_entry(i));
        logic signed [VW-1:0] dx;
        logic signed [VW-1:0] dy;

        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[i] < 0) begin
                    r_x[i+1] <= r_x[i] - dx;
                    r_y[i+1] <= r_y[i] + dy;
                    r_z[i+1] <= r_z[i] - T;
                end else begin
                    r_x[i+1] <= r_x[i] + dx;
                    r_y[i+1] <= r_y[i] - dy;
                    r_z[i+1] <= r_z[i] + T;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_mag <= mulq(r_x[CORDIC_STEPS], GAIN_K);
            o_ang <= r_z[CORDIC_STEPS];
        end
    end

endmodule

`default_nettype wire

FILE: src/great_circle_distance.sv
// ----------------------------------------------------------------------------
// great_circle_distance
// Central angle between two points on the unit sphere, Vincenty form, in
// Q30 fixed point with pipelined CORDIC sine/cosine and vectoring units.
// ----------------------------------------------------------------------------
//   channel   direction  handshake            payload
//   input     in         i_valid / o_ready    i_first_lng, i_first_lat,
//                                             i_second_lng, i_second_lat
//   result    out        o_valid / i_ready    o_distance
//   config    in         i_cfg_we             i_cfg_wdata (zero threshold)
//
// One item per cycle while the skid register is empty. Stages to the output
// register: one input register, 34 sine/cosine stages (three reduction steps,
// 30 rotation steps, sign fix-up), 3 multiply stages, two 32-stage vectoring
// units in series and 2 clamp/threshold stages. Synchronous active-low reset
// clears the pipeline valid bits and the output and skid valid flags, and loads
// a threshold of 1. The whole pipeline advances while the skid register is
// empty; a stalled result fills the skid register, which freezes the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module great_circle_distance (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [gcd_pkg::LNG_W-1:0]        i_first_lng,
    input  logic signed [gcd_pkg::LAT_W-1:0] i_first_lat,
    input  logic [gcd_pkg::LNG_W-1:0]        i_second_lng,
    input  logic signed [gcd_pkg::LAT_W-1:0] i_second_lat,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [gcd_pkg::OUT_W-1:0]        o_distance,
    input  logic                             i_cfg_we,
    input  logic [gcd_pkg::THR_W-1:0]        i_cfg_wdata
);
    import gcd_pkg::*;

    logic                   en;
    logic                   take;
    logic [TOTAL_LAT-1:0]   r_vld;
    logic [THR_W-1:0]       r_zero_thr;

    logic signed [AW-1:0]   r_lat1;
    logic signed [AW-1:0]   r_lat2;
    logic signed [AW-1:0]   r_dl;
    logic signed [LNG_W:0]  dl_raw;

    logic signed [VW-1:0]   s1, c1, s2, c2, sd, cd;
    logic signed [VW-1:0]   r_ta1, r_c1s2, r_s1c2, r_s1s2, r_c1c2, r_cd1;
    logic signed [VW-1:0]   r_ta2, r_c1s2b, r_s1s2b, r_q1, r_q2;
    logic signed [VW-1:0]   r_ta, r_tb, r_td;
    logic signed [VW-1:0]   r_tdd [0:VEC_LAT-1];
    logic signed [VW-1:0]   mag;
    logic signed [VW-1:0]   ang;

    logic signed [VW-1:0]   fc;
    logic [VW-1:0]          fr;
    logic [OUT_W-1:0]       r_d;
    logic [OUT_W-1:0]       r_dist;

    logic                   r_out_v;
    logic [OUT_W-1:0]       r_out_d;
    logic                   r_skid_v;
    logic [OUT_W-1:0]       r_skid_d;

    assign en      = ~r_skid_v;
    assign o_ready = en;
    assign take    = r_out_v & i_ready;
    assign dl_raw  = $signed({1'b0, i_first_lng}) - $signed({1'b0, i_second_lng});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_zero_thr <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[TOTAL_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lat1 <= AW'(i_first_lat) <<< IN_SHIFT;
            r_lat2 <= AW'(i_second_lat) <<< IN_SHIFT;
            r_dl   <= AW'(dl_raw) <<< IN_SHIFT;
        end
    end

    gcd_rot u_rot_lat1 (.i_clk(i_clk), .i_en(en), .i_ang(r_lat1), .o_sin(s1), .o_cos(c1));
    gcd_rot u_rot_lat2 (.i_clk(i_clk), .i_en(en), .i_ang(r_lat2), .o_sin(s2), .o_cos(c2));
    gcd_rot u_rot_dl   (.i_clk(i_clk), .i_en(en), .i_ang(r_dl),   .o_sin(sd), .o_cos(cd));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ta1   <= mulq(c2, sd);
            r_c1s2  <= mulq(c1, s2);
            r_s1c2  <= mulq(s1, c2);
            r_s1s2  <= mulq(s1, s2);
            r_c1c2  <= mulq(c1, c2);
            r_cd1   <= cd;

            r_ta2   <= r_ta1;
            r_c1s2b <= r_c1s2;
            r_s1s2b <= r_s1s2;
            r_q1    <= mulq(r_s1c2, r_cd1);
            r_q2    <= mulq(r_c1c2, r_cd1);

            r_ta    <= r_ta2;
            r_tb    <= r_c1s2b - r_q1;
            r_td    <= r_s1s2b + r_q2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tdd[0] <= r_td;
            for (int k = 1; k < VEC_LAT; k++) begin
                r_tdd[k] <= r_tdd[k-1];
            end
        end
    end

    gcd_vec u_vec_norm (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r_ta),
        .i_y   (r_tb),
        .o_mag (mag),
        .o_ang ()
    );

    gcd_vec u_vec_ang (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r_tdd[VEC_LAT-1]),
        .i_y   (mag),
        .o_mag (),
        .o_ang (ang)
    );

    always_comb begin
        if (ang < 0) begin
            fc = '0;
        end else if (ang > PI_V) begin
            fc = PI_V;
        end else begin
            fc = ang;
        end
        fr = ($unsigned(fc) + OUT_RND) >> OUT_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d    <= (fr > VW'(OUT_MAX)) ? OUT_MAX : OUT_W'(fr);
            r_dist <= (r_d <= OUT_W'(r_zero_thr)) ? '0 : r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (take) begin
                r_out_v  <= 1'b1;
                r_out_d  <= r_skid_d;
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || take) begin
            r_out_v <= r_vld[TOTAL_LAT-1];
            r_out_d <= r_dist;
        end else if (r_vld[TOTAL_LAT-1]) begin
            r_skid_v <= 1'b1;
            r_skid_d <= r_dist;
        end
    end

    assign o_valid    = r_out_v;
    assign o_distance = r_out_d;

endmodule

`default_nettype wire

FILE: src/gcd_chk.sv
// ----------------------------------------------------------------------------
// gcd_chk
// Port-level checks for the great-circle distance block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_chk (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic                             o_ready,
    input  logic [gcd_pkg::LNG_W-1:0]        i_first_lng,
    input  logic signed [gcd_pkg::LAT_W-1:0] i_first_lat,
    input  logic [gcd_pkg::LNG_W-1:0]        i_second_lng,
    input  logic signed [gcd_pkg::LAT_W-1:0] i_second_lat,
    input  logic                             o_valid,
    input  logic                             i_ready,
    input  logic [gcd_pkg::OUT_W-1:0]        o_distance,
    input  logic                             i_cfg_we,
    input  logic [gcd_pkg::THR_W-1:0]        i_cfg_wdata
);
    import gcd_pkg::*;

    logic [THR_W-1:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_distance))
        else $error("stalled result changed");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_distance <= OUT_PI)
        else $error("distance above pi");

    a_thresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_distance != '0 |-> o_distance > OUT_W'(r_thr))
        else $error("distance at or below threshold not zeroed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with no result waiting");

endmodule

bind great_circle_distance gcd_chk u_gcd_chk (.*);

`default_nettype wire
